FILE: hdl/spims_pkg.sv
// Package: shared types and constants for the SPI master shift engine.
`timescale 1ns / 1ps

package spims_pkg;

  localparam int unsigned TX_W     = 16;
  localparam int unsigned RX_W     = 8;
  localparam int unsigned HP_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLARITY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE       = 2'd2;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 16'd1;

  typedef struct packed {
    logic            mode;
    logic [TX_W-1:0] tx_word;
    logic            miso_level;
  } in_t;

  typedef struct packed {
    logic            sclk_level;
    logic            mosi_level;
    logic            nss_level;
    logic            busy_res;
    logic            done_res;
    logic [RX_W-1:0] rx_data;
  } out_t;

  typedef struct packed {
    logic [HP_W-1:0] half_period_ticks;
    logic            clock_polarity;
    logic            clock_phase;
  } cfg_t;

endpackage

FILE: hdl/spims_core.sv
// Serial engine state and per-transaction next-state logic.
`timescale 1ns / 1ps

module spims_core
  import spims_pkg::*;
#(
  parameter int unsigned BITS_PER_WORD = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  in_t  in_data_i,
  input  cfg_t cfg_i,
  output out_t result_o
);

  localparam int unsigned CW = $clog2(BITS_PER_WORD + 1);

  logic                     active_q, active_d;
  logic [CW-1:0]            bit_cnt_q, bit_cnt_d;
  logic [HP_W-1:0]          half_cnt_q, half_cnt_d;
  logic                     second_q, second_d;
  logic [BITS_PER_WORD-1:0] shift_out_q, shift_out_d;
  logic [BITS_PER_WORD-1:0] shift_in_q, shift_in_d;
  logic                     zero_q, zero_d;
  logic                     sclk_q, sclk_d;
  logic                     mosi_q, mosi_d;
  logic                     nss_q, nss_d;

  logic                     edge_lvl;
  logic [HP_W-1:0]          hp;
  logic [HP_W-1:0]          half_inc;
  logic [CW-1:0]            bit_next;
  logic                     done;
  logic [TX_W-1:0]          shift_in_ext;
  logic [RX_W-1:0]          rx;

  assign edge_lvl     = ~cfg_i.clock_polarity;
  assign hp           = (cfg_i.half_period_ticks == '0) ? HP_W'(1) : cfg_i.half_period_ticks;
  assign half_inc     = half_cnt_q + HP_W'(1);
  assign bit_next     = bit_cnt_q + CW'(1);
  assign shift_in_ext = TX_W'(shift_in_q);

  always_comb begin
    active_d    = active_q;
    bit_cnt_d   = bit_cnt_q;
    half_cnt_d  = half_cnt_q;
    second_d    = second_q;
    shift_out_d = shift_out_q;
    shift_in_d  = shift_in_q;
    zero_d      = zero_q;
    sclk_d      = sclk_q;
    mosi_d      = mosi_q;
    nss_d       = nss_q;
    done        = 1'b0;
    rx          = '0;
    if (accept_i) begin
      if (in_data_i.mode == MODE_START) begin
        if (!active_q) begin
          active_d    = 1'b1;
          bit_cnt_d   = '0;
          half_cnt_d  = '0;
          second_d    = 1'b0;
          shift_out_d = in_data_i.tx_word[BITS_PER_WORD-1:0];
          shift_in_d  = '0;
          zero_d      = (in_data_i.tx_word == '0);
          nss_d       = 1'b0;
          mosi_d      = in_data_i.tx_word[BITS_PER_WORD-1];
          sclk_d      = cfg_i.clock_phase ? edge_lvl : cfg_i.clock_polarity;
        end
      end else if (!active_q) begin
        sclk_d = cfg_i.clock_polarity;
      end else if (half_inc >= hp) begin
        half_cnt_d = '0;
        if (!second_q) begin
          // first half ends: sample MISO
          sclk_d     = cfg_i.clock_phase ? cfg_i.clock_polarity : edge_lvl;
          shift_in_d = (shift_in_q << 1) | BITS_PER_WORD'(in_data_i.miso_level);
          second_d   = 1'b1;
        end else begin
          second_d = 1'b0;
          if (!cfg_i.clock_phase) begin
            sclk_d = cfg_i.clock_polarity;
          end
          if (bit_next >= CW'(BITS_PER_WORD)) begin
            active_d  = 1'b0;
            bit_cnt_d = '0;
            nss_d     = 1'b1;
            sclk_d    = cfg_i.clock_polarity;
            done      = 1'b1;
            rx        = zero_q ? shift_in_ext[RX_W-1:0] : '0;
          end else begin
            bit_cnt_d   = bit_next;
            shift_out_d = shift_out_q << 1;
            mosi_d      = shift_out_q[BITS_PER_WORD-2+((BITS_PER_WORD == 1) ? 1 : 0)];
            if (BITS_PER_WORD == 1) begin
              mosi_d = 1'b0;
            end
            if (cfg_i.clock_phase) begin
              sclk_d = edge_lvl;
            end
          end
        end
      end else begin
        half_cnt_d = half_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      bit_cnt_q   <= '0;
      half_cnt_q  <= '0;
      second_q    <= 1'b0;
      shift_out_q <= '0;
      shift_in_q  <= '0;
      zero_q      <= 1'b0;
      sclk_q      <= 1'b0;
      mosi_q      <= 1'b0;
      nss_q       <= 1'b1;
    end else begin
      active_q    <= active_d;
      bit_cnt_q   <= bit_cnt_d;
      half_cnt_q  <= half_cnt_d;
      second_q    <= second_d;
      shift_out_q <= shift_out_d;
      shift_in_q  <= shift_in_d;
      zero_q      <= zero_d;
      sclk_q      <= sclk_d;
      mosi_q      <= mosi_d;
      nss_q       <= nss_d;
    end
  end

  always_comb begin
    result_o.sclk_level = sclk_d;
    result_o.mosi_level = mosi_d;
    result_o.nss_level  = nss_d;
    result_o.busy_res   = active_d;
    result_o.done_res   = done;
    result_o.rx_data    = rx;
  end

endmodule

FILE: hdl/spi_master_shift_engine.sv
// Top level: SPI master shift engine with config registers and result register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------
//   in      | input     | in_valid_i/stall_o | in_t
//   out     | output    | out_valid_o/stall_i| out_t
//   cfg     | input     | cfg_we_i           | idx, wdata
//
// One transaction per cycle while in_stall_o is low: each start or tick updates the engine
// state in the accepting cycle; its result appears in the output register in the next cycle.
// in_stall_o is high only while a held result is stalled downstream.
// Reset (async, active low): idle, NSS high, SCLK low, half period 1.
`timescale 1ns / 1ps

module spi_master_shift_engine
  import spims_pkg::*;
#(
  parameter int unsigned BITS_PER_WORD = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic out_valid_q;
  out_t out_data_q;
  out_t result;
  logic accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks <= HALF_PERIOD_RESET;
      cfg_q.clock_polarity    <= 1'b0;
      cfg_q.clock_phase       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_wdata_i[HP_W-1:0];
        CFG_POLARITY:    cfg_q.clock_polarity    <= cfg_wdata_i[0];
        CFG_PHASE:       cfg_q.clock_phase       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  spims_core #(
    .BITS_PER_WORD(BITS_PER_WORD)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_data_i(in_data_i),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hdl/spims_checker.sv
// Checker: port-level assertions for the SPI master shift engine, with bind.
`timescale 1ns / 1ps

module spims_checker
  import spims_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_done_ends_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res && out_data_o.nss_level)
    else $error("done reported while still busy or selected");

  a_rx_only_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |-> out_data_o.rx_data == '0)
    else $error("rx data nonzero without done");

  a_nss_tracks_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.nss_level != out_data_o.busy_res)
    else $error("chip select disagrees with busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind spi_master_shift_engine spims_checker u_spims_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

FILE: tb/sv/tb_top.sv
// Testbench for the SPI master shift engine: self-checking random and directed stimulus.
`timescale 1ns / 1ps

module tb_top;
  import spims_pkg::*;

  localparam int NUM_PHASES = 9;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTED = 30;
  localparam longint LIMIT_NS = 2_000_000;

  // Per-setting register values, index 0 at the right.
  localparam logic [8:0][15:0] HP_SEQ = {16'd1, 16'd2, 16'd4, 16'd1, 16'hFFFF,
                                         16'd3, 16'd0, 16'd2, 16'd1};
  localparam logic [8:0] POL_SEQ = 9'b010101010;
  localparam logic [8:0] PHA_SEQ = 9'b001101100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_HALF_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  in_t cmd_q[$];
  out_t expected_pins_q[$];
  int unsigned push_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned xfer_cnt = 0;
  int unsigned readback_cnt = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req_cnt = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // Shadow of the engine registers and state.
  logic [15:0] hp_cfg = HALF_PERIOD_RESET;
  logic pol_cfg = 1'b0;
  logic pha_cfg = 1'b0;
  logic busy_m = 1'b0;
  logic [4:0] bits_m = '0;
  logic [16:0] half_cnt_m = '0;
  logic second_m = 1'b0;
  logic [7:0] sh_out_m = '0;
  logic [7:0] sh_in_m = '0;
  logic zero_m = 1'b0;
  logic sclk_m = 1'b0;
  logic mosi_m = 1'b0;
  logic nss_m = 1'b1;

  spi_master_shift_engine uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic out_t spi_engine_step(input in_t it);
    out_t r;
    logic act;
    logic [16:0] hpe;
    logic done;
    logic [7:0] rx;
    act = ~pol_cfg;
    done = 1'b0;
    rx = '0;
    if (it.mode == MODE_START) begin
      if (!busy_m) begin
        busy_m = 1'b1;
        bits_m = '0;
        half_cnt_m = '0;
        second_m = 1'b0;
        sh_out_m = it.tx_word[7:0];
        sh_in_m = '0;
        zero_m = (it.tx_word == '0);
        nss_m = 1'b0;
        mosi_m = sh_out_m[7];
        sclk_m = pha_cfg ? act : pol_cfg;
      end
    end else if (!busy_m) begin
      sclk_m = pol_cfg;
    end else begin
      hpe = (hp_cfg == '0) ? 17'd1 : {1'b0, hp_cfg};
      half_cnt_m = half_cnt_m + 17'd1;
      if (half_cnt_m >= hpe) begin
        half_cnt_m = '0;
        if (!second_m) begin
          if (!pha_cfg) sclk_m = act;
          sh_in_m = {sh_in_m[6:0], it.miso_level};
          if (pha_cfg) sclk_m = pol_cfg;
          second_m = 1'b1;
        end else begin
          second_m = 1'b0;
          if (!pha_cfg) sclk_m = pol_cfg;
          bits_m = bits_m + 5'd1;
          if (bits_m >= 5'd8) begin
            busy_m = 1'b0;
            bits_m = '0;
            nss_m = 1'b1;
            sclk_m = pol_cfg;
            done = 1'b1;
            rx = zero_m ? sh_in_m : 8'h00;
            xfer_cnt++;
            if (zero_m) readback_cnt++;
          end else begin
            sh_out_m = {sh_out_m[6:0], 1'b0};
            mosi_m = sh_out_m[7];
            if (pha_cfg) sclk_m = act;
          end
        end
      end
    end
    r.sclk_level = sclk_m;
    r.mosi_level = mosi_m;
    r.nss_level = nss_m;
    r.busy_res = busy_m;
    r.done_res = done;
    r.rx_data = rx;
    return r;
  endfunction

  task automatic report_err(input string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, what);
  endtask

  function automatic void add_item(input in_t it);
    cmd_q.push_back(it);
    push_cnt++;
  endfunction

  function automatic in_t mk_tick(input logic miso);
    in_t it;
    it.mode = MODE_TICK;
    it.tx_word = 16'($urandom_range(0, 65535));
    it.miso_level = miso;
    return it;
  endfunction

  function automatic in_t mk_start(input logic [15:0] word);
    in_t it;
    it.mode = MODE_START;
    it.tx_word = word;
    it.miso_level = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly complete transfers with random data, some cut short, some noise.
  task automatic queue_phase(input int unsigned n);
    int unsigned left;
    int unsigned ticks;
    int unsigned hpe;
    in_t it;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 85) begin
        add_item(mk_start(rand_word()));
        left--;
        hpe = (hp_cfg == '0) ? 1 : hp_cfg;
        ticks = 16 * hpe + $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0) ticks = $urandom_range(1, 16 * hpe);
        while (ticks > 0 && left > 0) begin
          add_item(mk_tick(1'($urandom_range(0, 1))));
          ticks--;
          left--;
        end
      end else begin
        it.mode = 1'($urandom_range(0, 1));
        it.tx_word = rand_word();
        it.miso_level = 1'($urandom_range(0, 1));
        add_item(it);
        left--;
      end
    end
  endtask

  task automatic wait_quiet();
    while (accepted_cnt != push_cnt || expected_pins_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_cfg(input logic [15:0] hp, input logic pol, input logic pha);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_HALF_PERIOD;
    cfg_wdata <= hp;
    @(posedge clk);
    cfg_idx <= CFG_POLARITY;
    cfg_wdata <= {15'b0, pol};
    @(posedge clk);
    cfg_idx <= CFG_PHASE;
    cfg_wdata <= {15'b0, pha};
    @(posedge clk);
    cfg_we <= 1'b0;
    hp_cfg = hp;
    pol_cfg = pol;
    pha_cfg = pha;
  endtask

  // Sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_pins_q.push_back(spi_engine_step(in_data));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= cmd_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        result_cnt++;
        if (expected_pins_q.size() == 0) begin
          report_err($sformatf("unexpected transaction %p", out_data));
        end else begin
          exp_r = expected_pins_q.pop_front();
          if (out_data.sclk_level !== exp_r.sclk_level)
            report_err($sformatf("sclk %b, want %b", out_data.sclk_level, exp_r.sclk_level));
          if (out_data.mosi_level !== exp_r.mosi_level)
            report_err($sformatf("mosi %b, want %b", out_data.mosi_level, exp_r.mosi_level));
          if (out_data.nss_level !== exp_r.nss_level)
            report_err($sformatf("nss %b, want %b", out_data.nss_level, exp_r.nss_level));
          if (out_data.busy_res !== exp_r.busy_res)
            report_err($sformatf("busy %b, want %b", out_data.busy_res, exp_r.busy_res));
          if (out_data.done_res !== exp_r.done_res)
            report_err($sformatf("done %b, want %b", out_data.done_res, exp_r.done_res));
          if (out_data.rx_data !== exp_r.rx_data)
            report_err($sformatf("rx %h, want %h", out_data.rx_data, exp_r.rx_data));
        end
      end
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    logic [7:0] pat;
    pat = 8'hA5;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_quiet();
      if (p < 3) begin
        sender_idle_pct = 20;
        recv_idle_pct = 82;
      end else if (p < 6) begin
        sender_idle_pct = 82;
        recv_idle_pct = 20;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_cfg(HP_SEQ[p], POL_SEQ[p], PHA_SEQ[p]);
      if (p == 0) begin
        // idle tick, read-back transfer with start while busy, then a full-ones word
        add_item(mk_tick(1'b1));
        add_item(mk_start(16'h0000));
        add_item(mk_start(16'hFFFF));
        for (int k = 0; k < 16; k++) add_item(mk_tick(pat[7 - k / 2]));
        add_item(mk_tick(1'b0));
        add_item(mk_start(16'hFFFF));
        add_item(mk_tick(1'b1));
        add_item(mk_tick(1'b0));
      end
      if (p == 6) hold_req_cnt++;
      queue_phase(p == 0 ? 55 : (p == 4 ? 60 : 80));
    end
    wait_quiet();
    repeat (10) @(posedge clk);
    if (expected_pins_q.size() != 0)
      report_err($sformatf("%0d transactions never arrived", expected_pins_q.size()));
    $display("Run: %0d transactions checked over %0d register settings, %0d transfers done",
             result_cnt, NUM_PHASES, xfer_cnt);
    $display("     (%0d with read-back), all SPI modes, half periods 0 to 65535, with stalls",
             readback_cnt);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Timeout after %0d ns", LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
hdl/spims_pkg.sv
hdl/spims_core.sv
hdl/spi_master_shift_engine.sv
hdl/spims_checker.sv
tb/sv/tb_top.sv
